@@ rtl/core/ctzm_pkg.sv @@
// ctzm_pkg: shared widths, constants, codes and types of the CRS traveltime pipeline.
// No dependencies; every module of rtl/core refers to it by scoped names.
`timescale 1ns / 1ps

package ctzm_pkg;

  // Configuration port
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIME_STEP   = 2'd0,
    CFG_OFFSET_STEP = 2'd1,
    CFG_VELOCITY    = 2'd2
  } cfg_reg_t;

  localparam logic [CFG_W-1:0] TIME_STEP_RST   = 24'd67109;
  localparam logic [CFG_W-1:0] OFFSET_STEP_RST = 24'd6400;
  localparam logic [CFG_W-1:0] VELOCITY_RST    = 24'd512000;

  // Field and datapath widths
  localparam int SI_W     = 12;
  localparam int OI_W     = 8;
  localparam int ANG_W    = 18;
  localparam int NIP_W    = 32;
  localparam int T0_W     = 36;  // Q.24
  localparam int H_W      = 32;  // Q.8
  localparam int HSQ_W    = 64;  // Q.16
  localparam int TSQ_W    = 72;  // Q.48
  localparam int DEN_W    = 56;  // v0 * |radius|
  localparam int NUM_W    = 125; // 2*a*h^2 scaled to Q.48 times the divisor
  localparam int QUO_W    = 73;  // quotient bits kept exactly
  localparam int RADIC_W  = 64;
  localparam int ROOT_W   = 32;
  localparam int Q30_W    = 31;
  localparam int U_W      = 32;

  // Q30 one and angle fold points (Q.16)
  localparam logic [Q30_W-1:0] ONE_Q30     = 31'h4000_0000;
  localparam logic [ANG_W-1:0] HALF_PI_Q16 = 18'd102944;
  localparam logic [ANG_W-1:0] PI_Q16      = 18'd205887;

  // Horner divisors of the cosine series and their 2^32 reciprocals
  localparam int HORNER_N = 4;
  localparam logic [6:0] HORNER_DIV [HORNER_N] = '{7'd90, 7'd56, 7'd30, 7'd12};
  localparam logic [31:0] HORNER_RECIP [HORNER_N] = '{
    32'(64'd4294967296 / 64'd90),
    32'(64'd4294967296 / 64'd56),
    32'(64'd4294967296 / 64'd30),
    32'(64'd4294967296 / 64'd12)
  };

  // Cosine-squared unit stage count: fold, square, three stages per term, three to finish
  localparam int COS_LAT = 2 + 3 * HORNER_N + 3;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_NEG  = 2'd2,
    ST_SAT  = 2'd3
  } status_t;

  // Items that ride alongside the divider
  typedef struct packed {
    logic [TSQ_W-1:0] tsq;
    logic             neg;
    logic             zero;
  } div_side_t;

endpackage

@@ rtl/core/ctzm_cos_sq.sv @@
// ctzm_cos_sq: pipelined cos^2 of a Q.16 angle magnitude, Q30 result, fixed latency.
// Depends on ctzm_pkg (Horner divisors, reciprocals, widths).
`timescale 1ns / 1ps

module ctzm_cos_sq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [ctzm_pkg::ANG_W-1:0] in_mag,
  output logic                       out_valid,
  output logic [ctzm_pkg::Q30_W-1:0] out_c2
);

  // Fold stage
  logic                       fold_vld_r;
  logic [16:0]                fold_mag_r;
  logic [ctzm_pkg::ANG_W-1:0] fold_nxt;

  assign fold_nxt = (in_mag > ctzm_pkg::HALF_PI_Q16) ? ctzm_pkg::PI_Q16 - in_mag : in_mag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fold_vld_r <= 1'b0;
    end else begin
      fold_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    fold_mag_r <= fold_nxt[16:0];
  end

  // Term chain: u = mag^2 >> 2 and the running Horner term t
  logic                       chain_vld_r [0:ctzm_pkg::HORNER_N];
  logic [ctzm_pkg::U_W-1:0]   chain_u_r   [0:ctzm_pkg::HORNER_N];
  logic [ctzm_pkg::Q30_W-1:0] chain_t_r   [0:ctzm_pkg::HORNER_N];
  logic [33:0]                sq_nxt;

  assign sq_nxt = 34'(fold_mag_r) * 34'(fold_mag_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_vld_r[0] <= 1'b0;
    end else begin
      chain_vld_r[0] <= fold_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    chain_u_r[0] <= sq_nxt[33:2];
    chain_t_r[0] <= ctzm_pkg::ONE_Q30;
  end

  // One Horner term per block: multiply, reciprocal multiply, correct
  for (genvar k = 0; k < ctzm_pkg::HORNER_N; k++) begin : g_term
    logic                       a_vld_r, b_vld_r;
    logic [ctzm_pkg::U_W-1:0]   a_u_r, a_w_r, b_u_r, b_w_r;
    logic [63:0]                b_prod_r;
    logic [62:0]                ut_nxt;
    logic [63:0]                prod_nxt;
    logic [31:0]                est, est_d, rem, quo;
    logic [ctzm_pkg::Q30_W-1:0] t_nxt;

    assign ut_nxt   = 63'(chain_u_r[k]) * 63'(chain_t_r[k]);
    assign prod_nxt = 64'(a_w_r) * 64'(ctzm_pkg::HORNER_RECIP[k]);

    // est is floor(w/d) or one below it
    always_comb begin
      est   = b_prod_r[63:32];
      est_d = est * {25'd0, ctzm_pkg::HORNER_DIV[k]};
      rem   = b_w_r - est_d;
      quo   = (rem >= {25'd0, ctzm_pkg::HORNER_DIV[k]}) ? est + 32'd1 : est;
      t_nxt = ctzm_pkg::ONE_Q30 - quo[ctzm_pkg::Q30_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        a_vld_r          <= 1'b0;
        b_vld_r          <= 1'b0;
        chain_vld_r[k+1] <= 1'b0;
      end else begin
        a_vld_r          <= chain_vld_r[k];
        b_vld_r          <= a_vld_r;
        chain_vld_r[k+1] <= b_vld_r;
      end
    end

    always_ff @(posedge clk) begin
      a_u_r          <= chain_u_r[k];
      a_w_r          <= ut_nxt[61:30];
      b_u_r          <= a_u_r;
      b_w_r          <= a_w_r;
      b_prod_r       <= prod_nxt;
      chain_u_r[k+1] <= b_u_r;
      chain_t_r[k+1] <= t_nxt;
    end
  end

  // Finish: w = u*t, c = 1 - w/2 floored at zero, c2 = c*c
  logic                       fa_vld_r, fb_vld_r, fc_vld_r;
  logic [ctzm_pkg::U_W-1:0]   fa_w_r;
  logic [ctzm_pkg::Q30_W-1:0] fb_c_r, fc_c2_r;
  logic [62:0]                fut_nxt;
  logic [ctzm_pkg::Q30_W-1:0] p_nxt, c_nxt;
  logic [61:0]                cc_nxt;

  assign fut_nxt = 63'(chain_u_r[ctzm_pkg::HORNER_N]) * 63'(chain_t_r[ctzm_pkg::HORNER_N]);
  assign p_nxt   = fa_w_r[31:1];
  assign c_nxt   = (p_nxt >= ctzm_pkg::ONE_Q30) ? '0 : ctzm_pkg::ONE_Q30 - p_nxt;
  assign cc_nxt  = 62'(fb_c_r) * 62'(fb_c_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fa_vld_r <= 1'b0;
      fb_vld_r <= 1'b0;
      fc_vld_r <= 1'b0;
    end else begin
      fa_vld_r <= chain_vld_r[ctzm_pkg::HORNER_N];
      fb_vld_r <= fa_vld_r;
      fc_vld_r <= fb_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    fa_w_r  <= fut_nxt[61:30];
    fb_c_r  <= c_nxt;
    fc_c2_r <= cc_nxt[60:30];
  end

  assign out_valid = fc_vld_r;
  assign out_c2    = fc_c2_r;

endmodule

@@ rtl/core/ctzm_div.sv @@
// ctzm_div: restoring divider, one quotient bit per pipeline stage, with overflow flag.
// Depends on ctzm_pkg (widths, div_side_t).
`timescale 1ns / 1ps

module ctzm_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [ctzm_pkg::NUM_W-1:0] in_num,
  input  logic [ctzm_pkg::DEN_W-1:0] in_den,
  input  ctzm_pkg::div_side_t        in_side,
  output logic                       out_valid,
  output logic [ctzm_pkg::QUO_W-1:0] out_quo,
  output logic                       out_big,
  output ctzm_pkg::div_side_t        out_side
);

  localparam int NQ = ctzm_pkg::QUO_W;
  localparam int ND = ctzm_pkg::DEN_W;

  logic                       vld_r  [0:NQ];
  logic [ND-1:0]              rem_r  [0:NQ];
  logic [NQ-1:0]              low_r  [0:NQ];
  logic [NQ-1:0]              quo_r  [0:NQ];
  logic [ND-1:0]              den_r  [0:NQ];
  logic                       big_r  [0:NQ];
  ctzm_pkg::div_side_t        side_r [0:NQ];
  logic [ND-1:0]              hi_ext;

  // Quotient reaches 2^QUO_W exactly when the top dividend bits reach the divisor
  assign hi_ext = ND'(in_num[ctzm_pkg::NUM_W-1:NQ]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0]  <= hi_ext;
    low_r[0]  <= in_num[NQ-1:0];
    quo_r[0]  <= '0;
    den_r[0]  <= in_den;
    big_r[0]  <= (hi_ext >= in_den);
    side_r[0] <= in_side;
  end

  // One restoring step per stage
  for (genvar j = 1; j <= NQ; j++) begin : g_step
    logic [ND:0]   cur;
    logic          ge;
    logic [ND:0]   diff;

    assign cur  = {rem_r[j-1], low_r[j-1][NQ-1]};
    assign ge   = (cur >= {1'b0, den_r[j-1]});
    assign diff = cur - {1'b0, den_r[j-1]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else begin
        vld_r[j] <= vld_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[j]  <= ge ? diff[ND-1:0] : cur[ND-1:0];
      low_r[j]  <= {low_r[j-1][NQ-2:0], 1'b0};
      quo_r[j]  <= {quo_r[j-1][NQ-2:0], ge};
      den_r[j]  <= den_r[j-1];
      big_r[j]  <= big_r[j-1];
      side_r[j] <= side_r[j-1];
    end
  end

  assign out_valid = vld_r[NQ];
  assign out_quo   = quo_r[NQ];
  assign out_big   = big_r[NQ];
  assign out_side  = side_r[NQ];

endmodule

@@ rtl/core/ctzm_sqrt.sv @@
// ctzm_sqrt: pipelined integer square root of a 64-bit radicand, one root bit per stage.
// Depends on ctzm_pkg (widths, status_t).
`timescale 1ns / 1ps

module ctzm_sqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [ctzm_pkg::RADIC_W-1:0] in_rad,
  input  ctzm_pkg::status_t            in_status,
  output logic                         out_valid,
  output logic [ctzm_pkg::ROOT_W-1:0]  out_root,
  output ctzm_pkg::status_t            out_status
);

  localparam int NR = ctzm_pkg::ROOT_W;
  localparam int NV = ctzm_pkg::RADIC_W;
  localparam int RW = NR + 4;

  logic                 vld_r  [0:NR];
  logic [RW-3:0]        rem_r  [0:NR];
  logic [NR-1:0]        root_r [0:NR];
  logic [NV-1:0]        val_r  [0:NR];
  ctzm_pkg::status_t    st_r   [0:NR];

  // Input capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0]  <= '0;
    root_r[0] <= '0;
    val_r[0]  <= in_rad;
    st_r[0]   <= in_status;
  end

  // Bring down two radicand bits, try (root << 2) | 1
  for (genvar j = 1; j <= NR; j++) begin : g_step
    logic [RW-1:0] cur, trial, diff;
    logic          ge;

    assign cur   = {rem_r[j-1], val_r[j-1][NV-1:NV-2]};
    assign trial = {2'b00, root_r[j-1], 2'b01};
    assign ge    = (cur >= trial);
    assign diff  = cur - trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else begin
        vld_r[j] <= vld_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[j]  <= ge ? diff[RW-3:0] : cur[RW-3:0];
      root_r[j] <= {root_r[j-1][NR-2:0], ge};
      val_r[j]  <= {val_r[j-1][NV-3:0], 2'b00};
      st_r[j]   <= st_r[j-1];
    end
  end

  assign out_valid  = vld_r[NR];
  assign out_root   = root_r[NR];
  assign out_status = st_r[NR];

endmodule

@@ rtl/core/crs_traveltime_zero_midpoint_unit.sv @@
// crs_traveltime_zero_midpoint_unit: top level of the CRS zero-midpoint traveltime pipeline.
// Depends on ctzm_pkg, ctzm_cos_sq, ctzm_div and ctzm_sqrt.
`timescale 1ns / 1ps

// Fully pipelined: one item may be started in every clock cycle and busy is high only
// during reset. Each result appears on out_travel_time / out_status with out_strobe high
// for a single cycle; the receiver cannot hold it off, so it must take every beat. The
// items pass through the 17-stage cosine-squared unit, the restoring divider (73 stages,
// one quotient bit each) and the square root (32 stages, one root bit each). Status:
// 0 ok, 1 zero radius (time 0), 2 negative radicand (time 0), 3 saturated (time all
// ones). Write configuration only while no item is in flight.

module crs_traveltime_zero_midpoint_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [ctzm_pkg::SI_W-1:0]      in_sample_index,
  input  logic [ctzm_pkg::OI_W-1:0]      in_offset_index,
  input  logic signed [ctzm_pkg::ANG_W-1:0] in_emergence_angle,
  input  logic signed [ctzm_pkg::NIP_W-1:0] in_nip_radius,
  output logic                           out_strobe,
  output logic [ctzm_pkg::ROOT_W-1:0]    out_travel_time,
  output logic [1:0]                     out_status,
  input  logic                           cfg_we,
  input  logic [ctzm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ctzm_pkg::CFG_W-1:0]     cfg_data
);

  localparam int DLY_LEN  = ctzm_pkg::COS_LAT - 1;
  // Edges from the accepting edge to the edge that takes the beat
  localparam int PIPE_LAT = 130;

  typedef struct packed {
    logic [ctzm_pkg::T0_W-1:0]  t0;
    logic [ctzm_pkg::HSQ_W-1:0] hsq;
    logic [ctzm_pkg::TSQ_W-1:0] tsq;
    logic [ctzm_pkg::DEN_W-1:0] den;
    logic                       neg;
    logic                       zero;
  } pre_t;

  logic acc;
  assign busy = ~rst_n;
  assign acc  = start & ~busy;

  // Configuration registers
  logic [ctzm_pkg::CFG_W-1:0] time_step_r, offset_step_r, velocity_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r   <= ctzm_pkg::TIME_STEP_RST;
      offset_step_r <= ctzm_pkg::OFFSET_STEP_RST;
      velocity_r    <= ctzm_pkg::VELOCITY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ctzm_pkg::CFG_TIME_STEP:   time_step_r   <= cfg_data;
        ctzm_pkg::CFG_OFFSET_STEP: offset_step_r <= cfg_data;
        ctzm_pkg::CFG_VELOCITY:    velocity_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // S0: input capture
  logic                              s0_vld_r;
  logic [ctzm_pkg::SI_W-1:0]         s0_si_r;
  logic [ctzm_pkg::OI_W-1:0]         s0_oi_r;
  logic signed [ctzm_pkg::ANG_W-1:0] s0_ang_r;
  logic signed [ctzm_pkg::NIP_W-1:0] s0_nip_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s0_si_r  <= in_sample_index;
      s0_oi_r  <= in_offset_index;
      s0_ang_r <= in_emergence_angle;
      s0_nip_r <= in_nip_radius;
    end
  end

  // S1: t0, h, magnitudes
  logic                        s1_vld_r, s1_neg_r, s1_zero_r;
  logic [ctzm_pkg::T0_W-1:0]   s1_t0_r;
  logic [ctzm_pkg::H_W-1:0]    s1_h_r;
  logic [ctzm_pkg::ANG_W-1:0]  s1_mag_r;
  logic [ctzm_pkg::NIP_W-1:0]  s1_rmag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s0_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_t0_r   <= ctzm_pkg::T0_W'(s0_si_r) * ctzm_pkg::T0_W'(time_step_r);
    s1_h_r    <= ctzm_pkg::H_W'(s0_oi_r) * ctzm_pkg::H_W'(offset_step_r);
    s1_mag_r  <= s0_ang_r[ctzm_pkg::ANG_W-1] ? ctzm_pkg::ANG_W'(-s0_ang_r)
                                             : ctzm_pkg::ANG_W'(s0_ang_r);
    s1_rmag_r <= s0_nip_r[ctzm_pkg::NIP_W-1] ? ctzm_pkg::NIP_W'(-s0_nip_r)
                                             : ctzm_pkg::NIP_W'(s0_nip_r);
    s1_neg_r  <= s0_nip_r[ctzm_pkg::NIP_W-1];
    s1_zero_r <= (s0_nip_r == '0);
  end

  // Cosine-squared unit runs alongside S2 and the delay line
  logic                       cos_vld;
  logic [ctzm_pkg::Q30_W-1:0] cos_c2;

  ctzm_cos_sq u_cos_sq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_vld_r),
    .in_mag    (s1_mag_r),
    .out_valid (cos_vld),
    .out_c2    (cos_c2)
  );

  // S2: squares and divisor; zero velocity reads as one
  pre_t                       s2_r;
  logic [ctzm_pkg::CFG_W-1:0] v0_eff;

  assign v0_eff = (velocity_r == '0) ? ctzm_pkg::CFG_W'(1) : velocity_r;

  always_ff @(posedge clk) begin
    s2_r.t0   <= s1_t0_r;
    s2_r.hsq  <= ctzm_pkg::HSQ_W'(s1_h_r) * ctzm_pkg::HSQ_W'(s1_h_r);
    s2_r.tsq  <= ctzm_pkg::TSQ_W'(s1_t0_r) * ctzm_pkg::TSQ_W'(s1_t0_r);
    s2_r.den  <= ctzm_pkg::DEN_W'(v0_eff) * ctzm_pkg::DEN_W'(s1_rmag_r);
    s2_r.neg  <= s1_neg_r;
    s2_r.zero <= s1_zero_r;
  end

  // Delay line lines S2 up with the cosine result
  pre_t dly_r [0:DLY_LEN-1];

  always_ff @(posedge clk) begin
    dly_r[0] <= s2_r;
  end

  for (genvar i = 1; i < DLY_LEN; i++) begin : g_dly
    always_ff @(posedge clk) begin
      dly_r[i] <= dly_r[i-1];
    end
  end

  // S19: a = t0 * c2 >> 30
  logic                       s19_vld_r;
  pre_t                       s19_r;
  logic [ctzm_pkg::T0_W-1:0]  s19_a_r;
  logic [66:0]                tc_nxt;

  assign tc_nxt = 67'(dly_r[DLY_LEN-1].t0) * 67'(cos_c2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s19_vld_r <= 1'b0;
    end else begin
      s19_vld_r <= cos_vld;
    end
  end

  always_ff @(posedge clk) begin
    s19_r   <= dly_r[DLY_LEN-1];
    s19_a_r <= tc_nxt[65:30];
  end

  // S20: a * h^2 as two partial products
  logic        s20_vld_r;
  pre_t        s20_r;
  logic [67:0] s20_pp_lo_r, s20_pp_hi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s20_vld_r <= 1'b0;
    end else begin
      s20_vld_r <= s19_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s20_r       <= s19_r;
    s20_pp_lo_r <= 68'(s19_a_r) * 68'(s19_r.hsq[31:0]);
    s20_pp_hi_r <= 68'(s19_a_r) * 68'(s19_r.hsq[63:32]);
  end

  // S21: sum partial products, scale by 2 * 2^24
  logic                       s21_vld_r;
  pre_t                       s21_r;
  logic [ctzm_pkg::NUM_W-1:0] s21_num_r;
  logic [99:0]                prod_nxt;

  assign prod_nxt = {s20_pp_hi_r[67:0], 32'd0} + 100'(s20_pp_lo_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s21_vld_r <= 1'b0;
    end else begin
      s21_vld_r <= s20_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s21_r     <= s20_r;
    s21_num_r <= {prod_nxt, 25'd0};
  end

  // Divider
  ctzm_pkg::div_side_t        div_side_in, div_side;
  logic                       div_vld, div_big;
  logic [ctzm_pkg::QUO_W-1:0] div_quo;

  assign div_side_in.tsq  = s21_r.tsq;
  assign div_side_in.neg  = s21_r.neg;
  assign div_side_in.zero = s21_r.zero;

  ctzm_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s21_vld_r),
    .in_num    (s21_num_r),
    .in_den    (s21_r.den),
    .in_side   (div_side_in),
    .out_valid (div_vld),
    .out_quo   (div_quo),
    .out_big   (div_big),
    .out_side  (div_side)
  );

  // Radicand and special cases
  logic [ctzm_pkg::TSQ_W+1:0]   sum_nxt;
  logic [ctzm_pkg::TSQ_W-1:0]   diff_nxt;
  logic                         lt_nxt;
  logic [ctzm_pkg::RADIC_W-1:0] rad_nxt;
  ctzm_pkg::status_t            st_nxt;

  always_comb begin
    sum_nxt  = (ctzm_pkg::TSQ_W+2)'(div_side.tsq) + (ctzm_pkg::TSQ_W+2)'(div_quo);
    diff_nxt = div_side.tsq - div_quo[ctzm_pkg::TSQ_W-1:0];
    lt_nxt   = div_big || (ctzm_pkg::QUO_W'(div_side.tsq) < div_quo);
    rad_nxt  = '0;
    st_nxt   = ctzm_pkg::ST_OK;
    if (div_side.zero) begin
      st_nxt = ctzm_pkg::ST_ZERO;
    end else if (div_side.neg) begin
      if (lt_nxt) begin
        st_nxt = ctzm_pkg::ST_NEG;
      end else if (diff_nxt[ctzm_pkg::TSQ_W-1:ctzm_pkg::RADIC_W] != '0) begin
        st_nxt = ctzm_pkg::ST_SAT;
      end else begin
        rad_nxt = diff_nxt[ctzm_pkg::RADIC_W-1:0];
      end
    end else if (div_big || sum_nxt[ctzm_pkg::TSQ_W+1:ctzm_pkg::RADIC_W] != '0) begin
      st_nxt = ctzm_pkg::ST_SAT;
    end else begin
      rad_nxt = sum_nxt[ctzm_pkg::RADIC_W-1:0];
    end
  end

  // Square root
  logic                        sq_vld;
  logic [ctzm_pkg::ROOT_W-1:0] sq_root;
  ctzm_pkg::status_t           sq_st;

  ctzm_sqrt u_sqrt (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (div_vld),
    .in_rad     (rad_nxt),
    .in_status  (st_nxt),
    .out_valid  (sq_vld),
    .out_root   (sq_root),
    .out_status (sq_st)
  );

  // Output register
  logic                        out_strobe_r;
  logic [ctzm_pkg::ROOT_W-1:0] out_tt_r, tt_nxt;
  ctzm_pkg::status_t           out_st_r;

  always_comb begin
    case (sq_st)
      ctzm_pkg::ST_OK:  tt_nxt = sq_root;
      ctzm_pkg::ST_SAT: tt_nxt = '1;
      default:          tt_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_tt_r <= tt_nxt;
    out_st_r <= sq_st;
  end

  assign out_strobe      = out_strobe_r;
  assign out_travel_time = out_tt_r;
  assign out_status      = out_st_r;

`ifndef SYNTHESIS
  // Every beat traces back to an item taken a fixed latency earlier
  a_strobe_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(acc, PIPE_LAT))
    else $error("result beat without a matching item");

  // An item taken always yields exactly one beat
  a_item_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
    $past(acc, PIPE_LAT) && $past(rst_n, PIPE_LAT) && $stable(rst_n) |-> out_strobe)
    else $error("item taken but no result beat");

  // Saturation and the zero cases carry their fixed travel times
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_status == ctzm_pkg::ST_SAT |-> out_travel_time == '1)
    else $error("saturated beat not at full scale");

  a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_status == ctzm_pkg::ST_ZERO || out_status == ctzm_pkg::ST_NEG)
    |-> out_travel_time == '0)
    else $error("zero-time beat carries a value");
`endif

endmodule
